// ===== src/avtc_pkg.sv =====
// Shared types and constants for the A/V timestamp corrector.
package avtc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned FIXED_W = 64;
    localparam int unsigned CFG_W = 16;

    localparam logic [1:0] KIND_VIDEO = 2'd1;
    localparam logic [1:0] KIND_AUDIO = 2'd2;

    localparam logic [1:0] REG_MAX_VIDEO_JUMP = 2'd0;
    localparam logic [1:0] REG_DEFAULT_VIDEO_STEP = 2'd1;
    localparam logic [1:0] REG_MAX_AUDIO_JUMP = 2'd2;
    localparam logic [1:0] REG_DEFAULT_AUDIO_STEP = 2'd3;

    localparam logic [CFG_W-1:0] RST_MAX_VIDEO_JUMP = 16'd100;
    localparam logic [CFG_W-1:0] RST_DEFAULT_VIDEO_STEP = 16'd40;
    localparam logic [CFG_W-1:0] RST_MAX_AUDIO_JUMP = 16'd100;
    localparam logic [CFG_W-1:0] RST_DEFAULT_AUDIO_STEP = 16'd20;

    typedef struct packed {
        logic [CFG_W-1:0] max_video_jump;
        logic [CFG_W-1:0] default_video_step;
        logic [CFG_W-1:0] max_audio_jump;
        logic [CFG_W-1:0] default_audio_step;
    } cfg_t;

endpackage

// ===== src/av_timestamp_corrector.sv =====
// Top level of the A/V timestamp corrector: register port and packet datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per media packet:
//   packet_kind (0 other, 1 video, 2 audio, 3 other), is_codec_header and
//   raw_time in milliseconds. Output channel (out_valid/out_ready) returns
//   one fixed_time per request, in order: the low 32 bits of the corrected
//   timestamp, or 0 for headers and other packets.
//   The input register takes each request; the result register loads it from
//   there once the result register is empty or the receiver takes its value.
//   Throughput: one request per cycle while the receiver does not stall; the
//   timeline state is read and written back between the input and result registers.
//   While the receiver stalls, the result register holds its value and the
//   input register takes one more request, after which in_ready drops.
//   Reset clears both timelines, the audio-since-video count and the
//   handshake state, and loads the default jump and step registers.
//   The APB port (registers at 0x0, 0x4, 0x8, 0xC, 16 bits each) must be written
//   only while no request is in flight; the block itself does not enforce this.
module av_timestamp_corrector
    import avtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        packet_kind,
    input  logic              is_codec_header,
    input  logic [TIME_W-1:0] raw_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] fixed_time
);

    cfg_t cfg;

    avtc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    avtc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .packet_kind     (packet_kind),
        .is_codec_header (is_codec_header),
        .raw_time        (raw_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fixed_time      (fixed_time)
    );

endmodule

// ===== src/avtc_regs.sv =====
// APB configuration registers of the A/V timestamp corrector.
module avtc_regs
    import avtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_video_jump <= RST_MAX_VIDEO_JUMP;
            cfg_reg.default_video_step <= RST_DEFAULT_VIDEO_STEP;
            cfg_reg.max_audio_jump <= RST_MAX_AUDIO_JUMP;
            cfg_reg.default_audio_step <= RST_DEFAULT_AUDIO_STEP;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAX_VIDEO_JUMP:     cfg_reg.max_video_jump <= pwdata[CFG_W-1:0];
                REG_DEFAULT_VIDEO_STEP: cfg_reg.default_video_step <= pwdata[CFG_W-1:0];
                REG_MAX_AUDIO_JUMP:     cfg_reg.max_audio_jump <= pwdata[CFG_W-1:0];
                REG_DEFAULT_AUDIO_STEP: cfg_reg.default_audio_step <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_VIDEO_JUMP:     prdata = {16'd0, cfg_reg.max_video_jump};
            REG_DEFAULT_VIDEO_STEP: prdata = {16'd0, cfg_reg.default_video_step};
            REG_MAX_AUDIO_JUMP:     prdata = {16'd0, cfg_reg.max_audio_jump};
            REG_DEFAULT_AUDIO_STEP: prdata = {16'd0, cfg_reg.default_audio_step};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/avtc_core.sv =====
// Packet input register, timeline state, step logic and result register.
module avtc_core
    import avtc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        packet_kind,
    input  logic              is_codec_header,
    input  logic [TIME_W-1:0] raw_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TIME_W-1:0] fixed_time
);

    // -bound < d < bound; a bound of zero rejects every step
    function automatic logic step_ok(input logic signed [TIME_W:0] d,
                                     input logic [CFG_W-1:0] b);
        logic signed [TIME_W+1:0] dx;
        logic signed [TIME_W+1:0] bx;
        dx = {d[TIME_W], d};
        bx = {{(TIME_W+2-CFG_W){1'b0}}, b};
        return (dx < bx) && (dx > -bx);
    endfunction

    // input register
    logic              in_valid_reg;
    logic [1:0]        kind_reg;
    logic              hdr_reg;
    logic [TIME_W-1:0] time_reg;

    // timeline state
    logic               video_seen_reg, audio_seen_reg;
    logic [TIME_W-1:0]  video_last_reg, audio_last_reg;
    logic [FIXED_W-1:0] video_fixed_reg, audio_fixed_reg;
    logic [1:0]         since_video_reg;

    // result register
    logic              out_valid_reg;
    logic [TIME_W-1:0] fixed_time_reg;

    logic               advance;
    logic               is_video, is_audio;
    logic signed [TIME_W:0] dv, da, d_raw, d_use;
    logic [FIXED_W-1:0] base_fixed, stepped, result_fixed;
    logic [CFG_W-1:0]   bound, dflt;
    logic               vid_first, vid_sync, aud_by_audio, aud_start;
    logic [FIXED_W:0]   sum;
    logic [1:0]         since_video_next;

    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign fixed_time = fixed_time_reg;

    assign is_video = !hdr_reg && (kind_reg == KIND_VIDEO);
    assign is_audio = !hdr_reg && (kind_reg == KIND_AUDIO);

    assign dv = $signed({1'b0, time_reg}) - $signed({1'b0, video_last_reg});
    assign da = $signed({1'b0, time_reg}) - $signed({1'b0, audio_last_reg});

    assign vid_first = !video_seen_reg;
    // sync check uses t - audio_last; the range test is symmetric, so audio_last - t gives the same result
    assign vid_sync = vid_first && audio_seen_reg && !step_ok(da, cfg.max_video_jump);
    assign aud_by_audio = (since_video_reg != 2'd0);
    assign aud_start = aud_by_audio ? !audio_seen_reg : !video_seen_reg;
    assign since_video_next = (since_video_reg == 2'd0) ? 2'd1 : 2'd2;

    always_comb
    begin
        if (is_audio && aud_by_audio)
        begin
            d_raw = da;
            base_fixed = audio_fixed_reg;
            bound = cfg.max_audio_jump;
            dflt = cfg.default_audio_step;
        end
        else if (is_audio)
        begin
            d_raw = dv;
            base_fixed = video_fixed_reg;
            bound = cfg.max_video_jump;
            dflt = cfg.default_video_step;
        end
        else
        begin
            bound = cfg.max_video_jump;
            dflt = cfg.default_video_step;
            if (!vid_first)
            begin
                d_raw = dv;
                base_fixed = video_fixed_reg;
            end
            else if (vid_sync)
            begin
                d_raw = da;
                base_fixed = audio_fixed_reg;
            end
            else
            begin
                d_raw = '0;
                base_fixed = {{(FIXED_W-TIME_W){1'b0}}, time_reg};
            end
        end

        d_use = step_ok(d_raw, bound) ? d_raw
                                      : $signed({{(TIME_W+1-CFG_W){1'b0}}, dflt});
        sum = {1'b0, base_fixed} + {{(FIXED_W-TIME_W){d_use[TIME_W]}}, d_use};
        stepped = sum[FIXED_W] ? '0 : sum[FIXED_W-1:0];
        result_fixed = (is_audio && aud_start) ? {{(FIXED_W-TIME_W){1'b0}}, time_reg}
                                               : stepped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= packet_kind;
            hdr_reg <= is_codec_header;
            time_reg <= raw_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_seen_reg <= 1'b0;
            audio_seen_reg <= 1'b0;
            video_last_reg <= '0;
            audio_last_reg <= '0;
            video_fixed_reg <= '0;
            audio_fixed_reg <= '0;
            since_video_reg <= 2'd0;
        end
        else if (advance && is_video)
        begin
            video_seen_reg <= 1'b1;
            video_last_reg <= time_reg;
            video_fixed_reg <= result_fixed;
            since_video_reg <= 2'd0;
        end
        else if (advance && is_audio)
        begin
            audio_seen_reg <= 1'b1;
            audio_last_reg <= time_reg;
            audio_fixed_reg <= result_fixed;
            since_video_reg <= since_video_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fixed_time_reg <= (is_video || is_audio) ? result_fixed[TIME_W-1:0] : '0;
        end
    end

    a_since_video_sat: assert property (@(posedge clk) disable iff (!rst_n)
        since_video_reg != 2'd3)
        else $error("audio-since-video count beyond saturation");

    a_video_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_video) |=> (since_video_reg == 2'd0) && video_seen_reg)
        else $error("video request did not restart audio count");

    a_passive_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_video && !is_audio) |=>
            $stable(video_fixed_reg) && $stable(audio_fixed_reg) && $stable(since_video_reg))
        else $error("header or other request changed timeline state");

    a_passive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_video && !is_audio) |=> out_valid_reg && (fixed_time_reg == '0))
        else $error("header or other request gave nonzero result");

    a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(time_reg))
        else $error("stalled request lost from input register");

endmodule
